/* design/vcm_pkg.sv */
`timescale 1ns / 1ps

package vcm_pkg;

   // field widths
   localparam int XY_BITS       = 10;
   localparam int SLICE_BITS    = 6;
   localparam int DIR_FRAC_BITS = 14;
   localparam int FRAC_BITS     = 8;
   localparam int VOXEL_W       = 8;
   localparam int CFG_W         = 16;

   localparam int ORIGIN_W = XY_BITS + 9;
   localparam int DIR_W    = DIR_FRAC_BITS + 2;

   // point and offset widths
   localparam int PX_W  = XY_BITS + FRAC_BITS;
   localparam int PZ_W  = SLICE_BITS + CFG_W;
   localparam int DXY_W = ORIGIN_W + 1;
   localparam int DZ_W  = ((PZ_W > ORIGIN_W - 1) ? PZ_W : ORIGIN_W - 1) + 2;

   // cross product widths
   localparam int PXY_W = DXY_W + DIR_W;
   localparam int PZD_W = DZ_W + DIR_W;
   localparam int PRD_W = (PZD_W > PXY_W) ? PZD_W : PXY_W;
   localparam int CR_W  = PRD_W + 1;
   localparam int MAG_W = CR_W;

   // split squaring
   localparam int LO_W  = (MAG_W + 1) / 2;
   localparam int HI_W  = MAG_W - LO_W;
   localparam int SQ_W  = 2 * MAG_W;
   localparam int LHS_W = SQ_W + 2;

   // radius side
   localparam int RSQ_W = 2 * CFG_W;
   localparam int USQ_W = 2 * DIR_W - 1;
   localparam int DSQ_W = 2 * DIR_W + 1;
   localparam int RHS_W = RSQ_W + DSQ_W;
   localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;

   // stream packing
   localparam int COL_LSB      = 0;
   localparam int ROW_LSB      = XY_BITS;
   localparam int SLICE_LSB    = 2 * XY_BITS;
   localparam int VOX_LSB      = 2 * XY_BITS + SLICE_BITS;
   localparam int REQ_FIELDS_W = 2 * XY_BITS + SLICE_BITS + VOXEL_W;
   localparam int REQ_TDATA_W  = ((REQ_FIELDS_W + 7) / 8) * 8;

   localparam logic [VOXEL_W-1:0] MARK_VALUE = VOXEL_W'(255);

   // register file
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = (ORIGIN_W > CFG_W) ?
                               ((ORIGIN_W > DIR_W) ? ORIGIN_W : DIR_W) :
                               ((CFG_W > DIR_W) ? CFG_W : DIR_W);

   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_ORIGIN_Z = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_DIR_X    = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Y    = CSR_IDX_W'(4);
   localparam logic [CSR_IDX_W-1:0] REG_DIR_Z    = CSR_IDX_W'(5);
   localparam logic [CSR_IDX_W-1:0] REG_RADIUS   = CSR_IDX_W'(6);
   localparam logic [CSR_IDX_W-1:0] REG_Z_SCALE  = CSR_IDX_W'(7);

   localparam logic [ORIGIN_W-1:0] RST_ORIGIN_X = ORIGIN_W'(65536);
   localparam logic [ORIGIN_W-1:0] RST_ORIGIN_Y = ORIGIN_W'(65536);
   localparam logic [ORIGIN_W-1:0] RST_ORIGIN_Z = ORIGIN_W'(4096);
   localparam logic [DIR_W-1:0]    RST_DIR_X    = DIR_W'(0);
   localparam logic [DIR_W-1:0]    RST_DIR_Y    = DIR_W'(0);
   localparam logic [DIR_W-1:0]    RST_DIR_Z    = DIR_W'(16384);
   localparam logic [CFG_W-1:0]    RST_RADIUS   = CFG_W'(2560);
   localparam logic [CFG_W-1:0]    RST_Z_SCALE  = CFG_W'(1293);

   typedef struct packed {
      logic [ORIGIN_W-1:0] origin_x;
      logic [ORIGIN_W-1:0] origin_y;
      logic [ORIGIN_W-1:0] origin_z;
      logic [DIR_W-1:0]    dir_x;
      logic [DIR_W-1:0]    dir_y;
      logic [DIR_W-1:0]    dir_z;
      logic [CFG_W-1:0]    radius;
      logic [CFG_W-1:0]    z_scale;
   } cfg_type;

endpackage

/* design/vcm_delta.sv */
`timescale 1ns / 1ps

// point minus origin, one stage
module vcm_delta (
   input  logic                                   clock,
   input  logic                                   reset,
   input  vcm_pkg::cfg_type                       cfg,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [vcm_pkg::XY_BITS-1:0]            column,
   input  logic [vcm_pkg::XY_BITS-1:0]            row,
   input  logic [vcm_pkg::SLICE_BITS-1:0]         slice,
   input  logic [vcm_pkg::VOXEL_W-1:0]            voxel_in,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic signed [vcm_pkg::DXY_W-1:0]       dx,
   output logic signed [vcm_pkg::DXY_W-1:0]       dy,
   output logic signed [vcm_pkg::DZ_W-1:0]        dz,
   output logic [vcm_pkg::VOXEL_W-1:0]            voxel_out
);

   logic                               en;
   logic [vcm_pkg::PX_W-1:0]           px;
   logic [vcm_pkg::PX_W-1:0]           py;
   logic [vcm_pkg::PZ_W-1:0]           pz;
   logic                               valid_in, valid_ff;
   logic signed [vcm_pkg::DXY_W-1:0]   dx_in, dx_ff, dy_in, dy_ff;
   logic signed [vcm_pkg::DZ_W-1:0]    dz_in, dz_ff;
   logic [vcm_pkg::VOXEL_W-1:0]        vox_in, vox_ff;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   assign px = {column, {vcm_pkg::FRAC_BITS{1'b0}}};
   assign py = {row, {vcm_pkg::FRAC_BITS{1'b0}}};
   assign pz = vcm_pkg::PZ_W'(slice) * vcm_pkg::PZ_W'(cfg.z_scale);

   assign dx_in = vcm_pkg::DXY_W'($signed({1'b0, px}))
                - vcm_pkg::DXY_W'($signed(cfg.origin_x));
   assign dy_in = vcm_pkg::DXY_W'($signed({1'b0, py}))
                - vcm_pkg::DXY_W'($signed(cfg.origin_y));
   assign dz_in = vcm_pkg::DZ_W'($signed({1'b0, pz}))
                - vcm_pkg::DZ_W'($signed(cfg.origin_z));
   assign vox_in   = voxel_in;
   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         dz_ff  <= dz_in;
         vox_ff <= vox_in;
      end
   end

   assign out_valid = valid_ff;
   assign dx        = dx_ff;
   assign dy        = dy_ff;
   assign dz        = dz_ff;
   assign voxel_out = vox_ff;

endmodule

/* design/vcm_cross.sv */
`timescale 1ns / 1ps

// cross product magnitudes: products, then difference and abs
module vcm_cross (
   input  logic                                        clock,
   input  logic                                        reset,
   input  vcm_pkg::cfg_type                            cfg,
   input  logic                                        in_valid,
   output logic                                        in_ready,
   input  logic signed [vcm_pkg::DXY_W-1:0]            dx,
   input  logic signed [vcm_pkg::DXY_W-1:0]            dy,
   input  logic signed [vcm_pkg::DZ_W-1:0]             dz,
   input  logic [vcm_pkg::VOXEL_W-1:0]                 voxel_in,
   output logic                                        out_valid,
   input  logic                                        out_ready,
   output logic [2:0][vcm_pkg::MAG_W-1:0]              mag,
   output logic [vcm_pkg::VOXEL_W-1:0]                 voxel_out
);

   logic                                   en_a, en_b;
   logic                                   va_in, va_ff, vb_in, vb_ff;
   logic signed [vcm_pkg::PRD_W-1:0]       xs, ys, zs, ux, uy, uz;
   logic signed [vcm_pkg::PRD_W-1:0]       pa_in [3];
   logic signed [vcm_pkg::PRD_W-1:0]       pb_in [3];
   logic signed [vcm_pkg::PRD_W-1:0]       pa_ff [3];
   logic signed [vcm_pkg::PRD_W-1:0]       pb_ff [3];
   logic signed [vcm_pkg::CR_W-1:0]        dif [3];
   logic signed [vcm_pkg::CR_W-1:0]        neg [3];
   logic [2:0][vcm_pkg::MAG_W-1:0]         mag_in, mag_ff;
   logic [vcm_pkg::VOXEL_W-1:0]            vox_a_in, vox_a_ff, vox_b_in, vox_b_ff;

   assign en_b     = !vb_ff || out_ready;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   assign xs = vcm_pkg::PRD_W'(dx);
   assign ys = vcm_pkg::PRD_W'(dy);
   assign zs = vcm_pkg::PRD_W'(dz);
   assign ux = vcm_pkg::PRD_W'($signed(cfg.dir_x));
   assign uy = vcm_pkg::PRD_W'($signed(cfg.dir_y));
   assign uz = vcm_pkg::PRD_W'($signed(cfg.dir_z));

   // component k is pa - pb
   assign pa_in[0] = ys * uz;
   assign pb_in[0] = zs * uy;
   assign pa_in[1] = zs * ux;
   assign pb_in[1] = xs * uz;
   assign pa_in[2] = xs * uy;
   assign pb_in[2] = ys * ux;
   assign vox_a_in = voxel_in;
   assign va_in    = in_valid;

   // both differences in parallel, pick the non-negative one
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         dif[k]    = vcm_pkg::CR_W'(pa_ff[k]) - vcm_pkg::CR_W'(pb_ff[k]);
         neg[k]    = vcm_pkg::CR_W'(pb_ff[k]) - vcm_pkg::CR_W'(pa_ff[k]);
         mag_in[k] = dif[k][vcm_pkg::CR_W-1] ? neg[k] : dif[k];
      end
   end
   assign vox_b_in = vox_a_ff;
   assign vb_in    = va_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= va_in;
         end
         if (en_b) begin
            vb_ff <= vb_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         vox_a_ff <= vox_a_in;
      end
      if (en_b) begin
         mag_ff   <= mag_in;
         vox_b_ff <= vox_b_in;
      end
   end

   assign out_valid = vb_ff;
   assign mag       = mag_ff;
   assign voxel_out = vox_b_ff;

endmodule

/* design/vcm_square.sv */
`timescale 1ns / 1ps

// sum of squared magnitudes: half-width partial products, per-component
// square, then the three-way sum
module vcm_square (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   in_valid,
   output logic                                   in_ready,
   input  logic [2:0][vcm_pkg::MAG_W-1:0]         mag,
   input  logic [vcm_pkg::VOXEL_W-1:0]            voxel_in,
   output logic                                   out_valid,
   input  logic                                   out_ready,
   output logic [vcm_pkg::LHS_W-1:0]              lhs,
   output logic [vcm_pkg::VOXEL_W-1:0]            voxel_out
);

   localparam int HH_W = 2 * vcm_pkg::HI_W;
   localparam int HL_W = vcm_pkg::HI_W + vcm_pkg::LO_W;
   localparam int LL_W = 2 * vcm_pkg::LO_W;

   logic                              en_a, en_b, en_c;
   logic                              va_in, va_ff, vb_in, vb_ff, vc_in, vc_ff;
   logic [vcm_pkg::HI_W-1:0]          hi [3];
   logic [vcm_pkg::LO_W-1:0]          lo [3];
   logic [HH_W-1:0]                   hh_in [3];
   logic [HH_W-1:0]                   hh_ff [3];
   logic [HL_W-1:0]                   hl_in [3];
   logic [HL_W-1:0]                   hl_ff [3];
   logic [LL_W-1:0]                   ll_in [3];
   logic [LL_W-1:0]                   ll_ff [3];
   logic [vcm_pkg::SQ_W-1:0]          sq_in [3];
   logic [vcm_pkg::SQ_W-1:0]          sq_ff [3];
   logic [vcm_pkg::LHS_W-1:0]         lhs_in, lhs_ff;
   logic [vcm_pkg::VOXEL_W-1:0]       vox_a_in, vox_a_ff, vox_b_in, vox_b_ff;
   logic [vcm_pkg::VOXEL_W-1:0]       vox_c_in, vox_c_ff;

   assign en_c     = !vc_ff || out_ready;
   assign en_b     = !vb_ff || en_c;
   assign en_a     = !va_ff || en_b;
   assign in_ready = en_a;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         hi[k]    = mag[k][vcm_pkg::MAG_W-1:vcm_pkg::LO_W];
         lo[k]    = mag[k][vcm_pkg::LO_W-1:0];
         hh_in[k] = HH_W'(hi[k]) * HH_W'(hi[k]);
         hl_in[k] = HL_W'(hi[k]) * HL_W'(lo[k]);
         ll_in[k] = LL_W'(lo[k]) * LL_W'(lo[k]);
      end
   end

   // (h*2^L + l)^2 = h^2*2^2L + 2hl*2^L + l^2
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq_in[k] = (vcm_pkg::SQ_W'(hh_ff[k]) << (2 * vcm_pkg::LO_W))
                  + (vcm_pkg::SQ_W'(hl_ff[k]) << (vcm_pkg::LO_W + 1))
                  + vcm_pkg::SQ_W'(ll_ff[k]);
      end
   end

   assign lhs_in = vcm_pkg::LHS_W'(sq_ff[0]) + vcm_pkg::LHS_W'(sq_ff[1])
                 + vcm_pkg::LHS_W'(sq_ff[2]);

   assign va_in    = in_valid;
   assign vb_in    = va_ff;
   assign vc_in    = vb_ff;
   assign vox_a_in = voxel_in;
   assign vox_b_in = vox_a_ff;
   assign vox_c_in = vox_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (en_a) begin
            va_ff <= va_in;
         end
         if (en_b) begin
            vb_ff <= vb_in;
         end
         if (en_c) begin
            vc_ff <= vc_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en_a) begin
         hh_ff    <= hh_in;
         hl_ff    <= hl_in;
         ll_ff    <= ll_in;
         vox_a_ff <= vox_a_in;
      end
      if (en_b) begin
         sq_ff    <= sq_in;
         vox_b_ff <= vox_b_in;
      end
      if (en_c) begin
         lhs_ff   <= lhs_in;
         vox_c_ff <= vox_c_in;
      end
   end

   assign out_valid = vc_ff;
   assign lhs       = lhs_ff;
   assign voxel_out = vox_c_ff;

endmodule

/* design/vcm_rhs.sv */
`timescale 1ns / 1ps

// r^2 * |dir|^2 from the registers, free running, three stages
module vcm_rhs (
   input  logic                          clock,
   input  vcm_pkg::cfg_type              cfg,
   output logic [vcm_pkg::RHS_W-1:0]     rhs
);

   localparam int PW = 2 * vcm_pkg::DIR_W;

   logic signed [vcm_pkg::DIR_W-1:0]  u [3];
   logic signed [PW-1:0]              usq_full [3];
   logic [vcm_pkg::USQ_W-1:0]         usq_in [3];
   logic [vcm_pkg::USQ_W-1:0]         usq_ff [3];
   logic [vcm_pkg::RSQ_W-1:0]         rsq_in, rsq_ff, rsq2_in, rsq2_ff;
   logic [vcm_pkg::DSQ_W-1:0]         dsq_in, dsq_ff;
   logic [vcm_pkg::RHS_W-1:0]         rhs_in, rhs_ff;

   assign u[0] = $signed(cfg.dir_x);
   assign u[1] = $signed(cfg.dir_y);
   assign u[2] = $signed(cfg.dir_z);

   // a square is never negative and stays below 2^(2*DIR_W-1)
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         usq_full[k] = PW'(u[k]) * PW'(u[k]);
         usq_in[k]   = usq_full[k][vcm_pkg::USQ_W-1:0];
      end
   end

   assign rsq_in  = vcm_pkg::RSQ_W'(cfg.radius) * vcm_pkg::RSQ_W'(cfg.radius);
   assign dsq_in  = vcm_pkg::DSQ_W'(usq_ff[0]) + vcm_pkg::DSQ_W'(usq_ff[1])
                  + vcm_pkg::DSQ_W'(usq_ff[2]);
   assign rsq2_in = rsq_ff;
   assign rhs_in  = vcm_pkg::RHS_W'(rsq2_ff) * vcm_pkg::RHS_W'(dsq_ff);

   always_ff @(posedge clock) begin
      usq_ff  <= usq_in;
      rsq_ff  <= rsq_in;
      dsq_ff  <= dsq_in;
      rsq2_ff <= rsq2_in;
      rhs_ff  <= rhs_in;
   end

   assign rhs = rhs_ff;

endmodule

/* design/voxel_cylinder_marker_core.sv */
`timescale 1ns / 1ps

// Voxel cylinder marker. Each req word carries one voxel (column, row, slice,
// intensity); the block forms the point (column, row, slice * z_scale) in
// 8-bit fixed point and tests, exactly and without rounding, whether
// |(P - O) x D|^2 < radius^2 * |D|^2, i.e. whether the voxel lies strictly
// inside the cylinder of the given radius around the line through origin O
// along direction D. Inside voxels come out as 255 with rsp_tuser set, all
// others pass through unchanged with rsp_tuser clear. One rsp word per req
// word, in order. The datapath is a seven-register pipeline (offset, cross
// products, cross magnitudes, split squares, component squares, sum, compare
// and output); a new voxel is taken every cycle unless the output stalls;
// every stage holds under rsp_tready low and bubbles are squeezed out. The
// right-hand side r^2*|D|^2 is computed from the registers by a separate
// 3-stage path, so the registers may be written while the block is empty and
// a voxel may follow the write right away. A zero direction or zero radius
// marks nothing. csr_ready is always high.
module voxel_cylinder_marker_core (
   input  logic                                clock,
   input  logic                                reset,

   // config write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vcm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vcm_pkg::CSR_DATA_W-1:0]      csr_data,

   // voxel input stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // column, row, slice, voxel_in from bit 0 up, zero padded
   input  logic [vcm_pkg::REQ_TDATA_W-1:0]     req_tdata,

   // marked voxel stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // voxel_out
   output logic [vcm_pkg::VOXEL_W-1:0]         rsp_tdata,
   // inside_res
   output logic                                rsp_tuser
);

   // ---------------------------------------------------------------
   // register file
   // ---------------------------------------------------------------
   vcm_pkg::cfg_type cfg_in, cfg_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            vcm_pkg::REG_ORIGIN_X: cfg_in.origin_x = csr_data[vcm_pkg::ORIGIN_W-1:0];
            vcm_pkg::REG_ORIGIN_Y: cfg_in.origin_y = csr_data[vcm_pkg::ORIGIN_W-1:0];
            vcm_pkg::REG_ORIGIN_Z: cfg_in.origin_z = csr_data[vcm_pkg::ORIGIN_W-1:0];
            vcm_pkg::REG_DIR_X:    cfg_in.dir_x    = csr_data[vcm_pkg::DIR_W-1:0];
            vcm_pkg::REG_DIR_Y:    cfg_in.dir_y    = csr_data[vcm_pkg::DIR_W-1:0];
            vcm_pkg::REG_DIR_Z:    cfg_in.dir_z    = csr_data[vcm_pkg::DIR_W-1:0];
            vcm_pkg::REG_RADIUS:   cfg_in.radius   = csr_data[vcm_pkg::CFG_W-1:0];
            vcm_pkg::REG_Z_SCALE:  cfg_in.z_scale  = csr_data[vcm_pkg::CFG_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin_x <= vcm_pkg::RST_ORIGIN_X;
         cfg_ff.origin_y <= vcm_pkg::RST_ORIGIN_Y;
         cfg_ff.origin_z <= vcm_pkg::RST_ORIGIN_Z;
         cfg_ff.dir_x    <= vcm_pkg::RST_DIR_X;
         cfg_ff.dir_y    <= vcm_pkg::RST_DIR_Y;
         cfg_ff.dir_z    <= vcm_pkg::RST_DIR_Z;
         cfg_ff.radius   <= vcm_pkg::RST_RADIUS;
         cfg_ff.z_scale  <= vcm_pkg::RST_Z_SCALE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // ---------------------------------------------------------------
   // req word unpacking
   // ---------------------------------------------------------------
   logic [vcm_pkg::XY_BITS-1:0]     column;
   logic [vcm_pkg::XY_BITS-1:0]     row;
   logic [vcm_pkg::SLICE_BITS-1:0]  slice;
   logic [vcm_pkg::VOXEL_W-1:0]     voxel_in;

   assign column   = req_tdata[vcm_pkg::COL_LSB +: vcm_pkg::XY_BITS];
   assign row      = req_tdata[vcm_pkg::ROW_LSB +: vcm_pkg::XY_BITS];
   assign slice    = req_tdata[vcm_pkg::SLICE_LSB +: vcm_pkg::SLICE_BITS];
   assign voxel_in = req_tdata[vcm_pkg::VOX_LSB +: vcm_pkg::VOXEL_W];

   // ---------------------------------------------------------------
   // stage 1: offset from the origin
   // ---------------------------------------------------------------
   logic                                d_valid, d_ready;
   logic signed [vcm_pkg::DXY_W-1:0]    dx, dy;
   logic signed [vcm_pkg::DZ_W-1:0]     dz;
   logic [vcm_pkg::VOXEL_W-1:0]         d_vox;

   vcm_delta u_delta (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .column    (column),
      .row       (row),
      .slice     (slice),
      .voxel_in  (voxel_in),
      .out_valid (d_valid),
      .out_ready (d_ready),
      .dx        (dx),
      .dy        (dy),
      .dz        (dz),
      .voxel_out (d_vox)
   );

   // ---------------------------------------------------------------
   // stages 2-3: cross product and its component magnitudes
   // ---------------------------------------------------------------
   logic                                  c_valid, c_ready;
   logic [2:0][vcm_pkg::MAG_W-1:0]        mag;
   logic [vcm_pkg::VOXEL_W-1:0]           c_vox;

   vcm_cross u_cross (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (d_valid),
      .in_ready  (d_ready),
      .dx        (dx),
      .dy        (dy),
      .dz        (dz),
      .voxel_in  (d_vox),
      .out_valid (c_valid),
      .out_ready (c_ready),
      .mag       (mag),
      .voxel_out (c_vox)
   );

   // ---------------------------------------------------------------
   // stages 4-6: |d x dir|^2
   // ---------------------------------------------------------------
   logic                              s_valid, s_ready;
   logic [vcm_pkg::LHS_W-1:0]         lhs;
   logic [vcm_pkg::VOXEL_W-1:0]       s_vox;

   vcm_square u_square (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c_valid),
      .in_ready  (c_ready),
      .mag       (mag),
      .voxel_in  (c_vox),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .lhs       (lhs),
      .voxel_out (s_vox)
   );

   // r^2 * |dir|^2 from the register file
   logic [vcm_pkg::RHS_W-1:0] rhs;

   vcm_rhs u_rhs (
      .clock (clock),
      .cfg   (cfg_ff),
      .rhs   (rhs)
   );

   // ---------------------------------------------------------------
   // stage 7: compare and output register
   // ---------------------------------------------------------------
   logic                          out_en;
   logic                          in_cyl;
   logic                          rsp_valid_in, rsp_valid_ff;
   logic [vcm_pkg::VOXEL_W-1:0]   rsp_vox_in, rsp_vox_ff;
   logic                          rsp_inside_in, rsp_inside_ff;

   assign out_en  = !rsp_valid_ff || rsp_tready;
   assign s_ready = out_en;

   // strict less-than: a point on the surface is outside
   assign in_cyl        = vcm_pkg::CMP_W'(lhs) < vcm_pkg::CMP_W'(rhs);
   assign rsp_valid_in  = s_valid;
   assign rsp_vox_in    = in_cyl ? vcm_pkg::MARK_VALUE : s_vox;
   assign rsp_inside_in = in_cyl;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_en) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_vox_ff    <= rsp_vox_in;
         rsp_inside_ff <= rsp_inside_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_vox_ff;
   assign rsp_tuser  = rsp_inside_ff;

endmodule

/* sim/tb_voxel_cylinder_marker_core.sv */
`timescale 1ns / 1ps

module tb_voxel_cylinder_marker_core;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int RANDOM_ITEMS = 1650;
   localparam int DRAIN_CYCLES = 12;      // pipeline depth plus margin
   localparam int PAD_W        = vcm_pkg::CSR_DATA_W - vcm_pkg::CFG_W;

   typedef struct {
      bit [vcm_pkg::VOXEL_W-1:0] voxel_out;
      bit                        hit;
   } mark_type;

   // keeps a copy of the register file, predicts the mark for every accepted
   // voxel and compares it with what comes out of the block
   class cylinder_scoreboard;
      vcm_pkg::cfg_type cfg;
      mark_type         marks_due[$];
      int               errors;
      int               inside_seen;

      function new();
         cfg.origin_x = vcm_pkg::RST_ORIGIN_X;
         cfg.origin_y = vcm_pkg::RST_ORIGIN_Y;
         cfg.origin_z = vcm_pkg::RST_ORIGIN_Z;
         cfg.dir_x    = vcm_pkg::RST_DIR_X;
         cfg.dir_y    = vcm_pkg::RST_DIR_Y;
         cfg.dir_z    = vcm_pkg::RST_DIR_Z;
         cfg.radius   = vcm_pkg::RST_RADIUS;
         cfg.z_scale  = vcm_pkg::RST_Z_SCALE;
      endfunction

      function void write_reg(bit [vcm_pkg::CSR_IDX_W-1:0] idx,
                              bit [vcm_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            vcm_pkg::REG_ORIGIN_X: cfg.origin_x = data[vcm_pkg::ORIGIN_W-1:0];
            vcm_pkg::REG_ORIGIN_Y: cfg.origin_y = data[vcm_pkg::ORIGIN_W-1:0];
            vcm_pkg::REG_ORIGIN_Z: cfg.origin_z = data[vcm_pkg::ORIGIN_W-1:0];
            vcm_pkg::REG_DIR_X:    cfg.dir_x    = data[vcm_pkg::DIR_W-1:0];
            vcm_pkg::REG_DIR_Y:    cfg.dir_y    = data[vcm_pkg::DIR_W-1:0];
            vcm_pkg::REG_DIR_Z:    cfg.dir_z    = data[vcm_pkg::DIR_W-1:0];
            vcm_pkg::REG_RADIUS:   cfg.radius   = data[vcm_pkg::CFG_W-1:0];
            vcm_pkg::REG_Z_SCALE:  cfg.z_scale  = data[vcm_pkg::CFG_W-1:0];
            default: ;
         endcase
      endfunction

      // exact test |(P - O) x D|^2 < r^2 * |D|^2, no rounding anywhere
      function void note_voxel(bit [vcm_pkg::XY_BITS-1:0] col,
                               bit [vcm_pkg::XY_BITS-1:0] row,
                               bit [vcm_pkg::SLICE_BITS-1:0] slc,
                               bit [vcm_pkg::VOXEL_W-1:0] vin);
         longint    dx, dy, dz, ux, uy, uz, crx, cry, crz, dir_sq;
         bit [127:0] mx, my, mz, dist_sq, r_sq, lim_sq;
         mark_type  m;
         dx  = (longint'(col) <<< vcm_pkg::FRAC_BITS) - longint'($signed(cfg.origin_x));
         dy  = (longint'(row) <<< vcm_pkg::FRAC_BITS) - longint'($signed(cfg.origin_y));
         dz  = longint'(slc) * longint'(cfg.z_scale) - longint'($signed(cfg.origin_z));
         ux  = longint'($signed(cfg.dir_x));
         uy  = longint'($signed(cfg.dir_y));
         uz  = longint'($signed(cfg.dir_z));
         crx = dy * uz - dz * uy;
         cry = dz * ux - dx * uz;
         crz = dx * uy - dy * ux;
         mx  = (crx < 0) ? -crx : crx;
         my  = (cry < 0) ? -cry : cry;
         mz  = (crz < 0) ? -crz : crz;
         dist_sq = mx * mx + my * my + mz * mz;
         dir_sq  = ux * ux + uy * uy + uz * uz;
         r_sq    = 128'(cfg.radius) * 128'(cfg.radius);
         lim_sq  = r_sq * 128'(dir_sq);
         m.hit       = dist_sq < lim_sq;
         m.voxel_out = m.hit ? vcm_pkg::MARK_VALUE : vin;
         marks_due = {marks_due, m};
      endfunction

      function int pending();
         return marks_due.size();
      endfunction

      task report(string msg);
         // keep the log short when something is badly broken
         if (errors < 50)
            $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      task check_marked(bit [vcm_pkg::VOXEL_W-1:0] vout, bit ins);
         mark_type m;
         if (marks_due.size() == 0) begin
            report($sformatf("unexpected word voxel_out=%0d inside=%0d", vout, ins));
         end else begin
            m = marks_due.pop_front();
            if (ins)
               inside_seen++;
            if (vout !== m.voxel_out)
               report($sformatf("voxel_out got %0d want %0d", vout, m.voxel_out));
            if (ins !== m.hit)
               report($sformatf("inside got %0d want %0d", ins, m.hit));
         end
      endtask
   endclass

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [vcm_pkg::CSR_IDX_W-1:0]    csr_index  = '0;
   logic [vcm_pkg::CSR_DATA_W-1:0]   csr_data   = '0;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [vcm_pkg::REQ_TDATA_W-1:0]  req_tdata  = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [vcm_pkg::VOXEL_W-1:0]      rsp_tdata;
   logic                             rsp_tuser;

   cylinder_scoreboard sb = new();

   int cycle_count = 0;
   int sent_count  = 0;
   int setting_count = 0;
   int burst_left  = 0;

   // current random setting, kept as plain integers for aiming voxels
   int ph_ox, ph_oy, ph_oz, ph_dx, ph_dy, ph_dz, ph_rad, ph_zs;

   voxel_cylinder_marker_core dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: check the word taken at this edge, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_marked(rsp_tdata, rsp_tuser);
      case ((cycle_count / 300) % 4)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         2: rsp_tready <= (cycle_count % 4) != 0;
         default: rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   // narrow registers get junk above their width, which must be dropped
   function automatic bit [vcm_pkg::CSR_DATA_W-1:0] with_junk(int v);
      return {PAD_W'($urandom), vcm_pkg::CFG_W'(v)};
   endfunction

   function automatic int pick_dir();
      case ($urandom_range(0, 11))
         0: return -32768;
         1: return -16384;
         2: return 16384;
         3: return 0;
         default: return int'($urandom_range(0, 32768)) - 16384;
      endcase
   endfunction

   task automatic csr_write(bit [vcm_pkg::CSR_IDX_W-1:0] idx,
                            bit [vcm_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
   endtask

   task automatic send_voxel(bit [vcm_pkg::XY_BITS-1:0] col,
                             bit [vcm_pkg::XY_BITS-1:0] row,
                             bit [vcm_pkg::SLICE_BITS-1:0] slc,
                             bit [vcm_pkg::VOXEL_W-1:0] vin);
      req_tvalid <= 1'b1;
      req_tdata  <= vcm_pkg::REQ_TDATA_W'({vin, slc, row, col});
      do @(posedge clock); while (!req_tready);
      sb.note_voxel(col, row, slc, vin);
      sent_count++;
   endtask

   // stop sending and wait until every mark has come back
   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // bursts of random length, sometimes back to back
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 64);
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic pick_config();
      case ($urandom_range(0, 9))
         0: ph_zs = 0;
         1: ph_zs = 65535;
         default: ph_zs = $urandom_range(64, 2048);
      endcase
      case ($urandom_range(0, 9))
         0: ph_rad = 0;
         1: ph_rad = 65535;
         default: ph_rad = $urandom_range(1, 40 * 256);
      endcase
      case ($urandom_range(0, 9))
         0: ph_ox = -262144;
         1: ph_ox = 262143;
         default: ph_ox = $urandom_range(0, 1023 * 256);
      endcase
      case ($urandom_range(0, 9))
         0: ph_oy = -262144;
         1: ph_oy = 262143;
         default: ph_oy = $urandom_range(0, 1023 * 256);
      endcase
      case ($urandom_range(0, 9))
         0: ph_oz = -262144;
         1: ph_oz = 262143;
         default: ph_oz = $urandom_range(0, 63 * ph_zs);
      endcase
      ph_dx = pick_dir();
      ph_dy = pick_dir();
      ph_dz = pick_dir();
      drain_pipeline();
      csr_write(vcm_pkg::REG_ORIGIN_X, vcm_pkg::CSR_DATA_W'(ph_ox));
      csr_write(vcm_pkg::REG_ORIGIN_Y, vcm_pkg::CSR_DATA_W'(ph_oy));
      csr_write(vcm_pkg::REG_ORIGIN_Z, vcm_pkg::CSR_DATA_W'(ph_oz));
      csr_write(vcm_pkg::REG_DIR_X, with_junk(ph_dx));
      csr_write(vcm_pkg::REG_DIR_Y, with_junk(ph_dy));
      csr_write(vcm_pkg::REG_DIR_Z, with_junk(ph_dz));
      csr_write(vcm_pkg::REG_RADIUS, with_junk(ph_rad));
      csr_write(vcm_pkg::REG_Z_SCALE, with_junk(ph_zs));
      csr_valid <= 1'b0;
      setting_count++;
   endtask

   // most voxels are aimed at the line, the rest land anywhere
   task automatic send_random_voxel();
      int t, span, col, row, slc;
      pace_sender();
      if ($urandom_range(0, 9) < 4) begin
         send_voxel(vcm_pkg::XY_BITS'($urandom), vcm_pkg::XY_BITS'($urandom),
                    vcm_pkg::SLICE_BITS'($urandom), vcm_pkg::VOXEL_W'($urandom));
      end else begin
         t    = int'($urandom_range(0, 80)) - 40;
         span = (ph_rad >>> 8) + 3;
         col  = ((ph_ox + t * ph_dx / 64) >>> 8) + int'($urandom_range(0, 2 * span)) - span;
         row  = ((ph_oy + t * ph_dy / 64) >>> 8) + int'($urandom_range(0, 2 * span)) - span;
         if (ph_zs > 0)
            slc = (ph_oz + t * ph_dz / 64) / ph_zs + int'($urandom_range(0, 4)) - 2;
         else
            slc = $urandom_range(0, 63);
         send_voxel(vcm_pkg::XY_BITS'(clamp(col, 0, 1023)),
                    vcm_pkg::XY_BITS'(clamp(row, 0, 1023)),
                    vcm_pkg::SLICE_BITS'(clamp(slc, 0, 63)),
                    vcm_pkg::VOXEL_W'($urandom));
      end
   endtask

   initial begin
      int n, phase_len;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset setting: line along z through voxel (256, 256), radius 10
      send_voxel(256, 256, 0, 8'h00);      // on the axis
      send_voxel(265, 256, 63, 8'h5a);     // just inside
      send_voxel(266, 256, 5, 8'ha5);      // exactly on the radius, stays out
      send_voxel(256, 266, 10, 8'h3c);     // on the radius along y
      send_voxel(263, 263, 1, 8'h01);      // diagonal inside
      send_voxel(263, 264, 2, 8'hfe);      // diagonal just outside
      send_voxel(0, 0, 0, 8'h00);          // field minimum
      send_voxel(1023, 1023, 63, 8'hff);   // field maximum

      // zero direction marks nothing
      drain_pipeline();
      csr_write(vcm_pkg::REG_DIR_Z, '0);
      csr_valid <= 1'b0;
      send_voxel(256, 256, 16, 8'h07);
      send_voxel(260, 250, 3, 8'h80);

      // zero radius marks nothing, not even on the axis
      drain_pipeline();
      csr_write(vcm_pkg::REG_DIR_Z, vcm_pkg::CSR_DATA_W'(16384));
      csr_write(vcm_pkg::REG_RADIUS, '0);
      csr_valid <= 1'b0;
      send_voxel(256, 256, 16, 8'h09);
      send_voxel(256, 256, 0, 8'h10);

      // most negative direction taken at face value, junk bits above dropped
      drain_pipeline();
      csr_write(vcm_pkg::REG_DIR_Z, {PAD_W'('1), 16'h8000});
      csr_write(vcm_pkg::REG_RADIUS, vcm_pkg::CSR_DATA_W'(10 * 256));
      csr_valid <= 1'b0;
      send_voxel(256, 256, 40, 8'h22);
      send_voxel(266, 256, 40, 8'h44);

      // register extremes
      drain_pipeline();
      csr_write(vcm_pkg::REG_ORIGIN_X, vcm_pkg::CSR_DATA_W'(262143));
      csr_write(vcm_pkg::REG_ORIGIN_Y, vcm_pkg::CSR_DATA_W'(-262144));
      csr_write(vcm_pkg::REG_ORIGIN_Z, vcm_pkg::CSR_DATA_W'(-262144));
      csr_write(vcm_pkg::REG_DIR_X, vcm_pkg::CSR_DATA_W'(16384));
      csr_write(vcm_pkg::REG_DIR_Y, vcm_pkg::CSR_DATA_W'(-16384));
      csr_write(vcm_pkg::REG_DIR_Z, vcm_pkg::CSR_DATA_W'(16384));
      csr_write(vcm_pkg::REG_RADIUS, vcm_pkg::CSR_DATA_W'(65535));
      csr_write(vcm_pkg::REG_Z_SCALE, vcm_pkg::CSR_DATA_W'(65535));
      csr_valid <= 1'b0;
      send_voxel(1023, 0, 63, 8'h55);
      send_voxel(0, 1023, 0, 8'haa);
      send_voxel(1023, 1023, 63, 8'h0f);
      setting_count = 5;

      // random settings, each followed by a stretch of voxels
      n = 0;
      while (n < RANDOM_ITEMS) begin
         pick_config();
         phase_len = $urandom_range(80, 130);
         repeat (phase_len) begin
            send_random_voxel();
            n++;
         end
      end

      drain_pipeline();
      $display("covered %0d voxels under %0d register settings, %0d marked inside",
               sent_count, setting_count, sb.inside_seen);
      if (sb.errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* files.f */
design/vcm_pkg.sv
design/vcm_delta.sv
design/vcm_cross.sv
design/vcm_square.sv
design/vcm_rhs.sv
design/voxel_cylinder_marker_core.sv
sim/tb_voxel_cylinder_marker_core.sv
